FILE: src/lpcd_pkg.sv
// Package for the length-prefixed command deframer.
// Holds the transaction structs, status and phase codes, and sizing constants.
// No dependencies.
package lpcd_pkg;

  // Default width of the running byte position counter.
  localparam int OFFSET_BITS_DEFAULT = 32;

  // Number of command types after reset.
  localparam logic [31:0] TYPE_COUNT_RESET = 32'd32;

  // Header length in bytes and the smallest legal encoded size.
  localparam int HEADER_BYTES = 8;
  localparam int HDR_IDX_W = $clog2(HEADER_BYTES);
  localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HEADER_BYTES - 1);
  localparam logic [31:0] MIN_SIZE = 32'(HEADER_BYTES);

  // Depth of the result queue between the parser and the output side.
  localparam int QUEUE_DEPTH = 2;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_SIZE = 3'd1,
    ST_TRUNC    = 3'd2,
    ST_BAD_TYPE = 3'd3,
    ST_DONE     = 3'd4
  } status_t;

  // Parser phase, one-hot.
  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_BODY   = 3'b010,
    PH_SKIP   = 3'b100
  } phase_t;

  // One input transaction.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       is_last;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] cmd_type;
    logic [31:0] command_offset;
    logic [31:0] cmd_size;
    logic        payload_end;
  } result_t;

endpackage

FILE: src/lpcd_parse.sv
// Front part of the deframer: takes one payload byte per transaction, tracks
// header and body progress, and classifies finished or broken commands.
// Depends on lpcd_pkg.
module lpcd_parse import lpcd_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  item_t       item,
  input  logic        type_count_we,
  input  logic [31:0] type_count_wdata,
  output logic        emit,
  output result_t     res
);

  phase_t                 phase, phase_next;
  logic [HDR_IDX_W-1:0]   hbs, hbs_next;
  logic [63:0]            header_word, hw_next, hw_ins;
  logic [31:0]            body_remaining, rem_next, rem_dec;
  logic [OFFSET_BITS-1:0] byte_position, pos_next;
  logic [OFFSET_BITS-1:0] start_position, start_next, start_cur;
  logic                   type_invalid, tinv_next, tinv_now;
  logic [31:0]            type_count;
  logic                   finish;
  status_t                st;
  logic [31:0]            ty, sz;

  // Next-state and result decode for the byte being accepted.
  always_comb begin
    phase_next = phase;
    hbs_next   = hbs;
    hw_next    = header_word;
    rem_next   = body_remaining;
    start_cur  = start_position;
    start_next = start_position;
    tinv_next  = type_invalid;
    pos_next   = byte_position;
    emit       = 1'b0;
    st         = ST_OK;
    ty         = header_word[31:0];
    sz         = header_word[63:32];
    finish     = 1'b0;
    tinv_now   = type_invalid;
    rem_dec    = body_remaining - 32'd1;
    hw_ins     = header_word;
    hw_ins[{hbs, 3'b000} +: 8] = item.payload_byte;

    if (accept) begin
      unique case (phase)
        PH_BODY: begin
          rem_next = rem_dec;
          if (rem_dec == 32'd0) begin
            finish = 1'b1;
          end else if (item.is_last) begin
            emit = 1'b1;
            st   = ST_TRUNC;
          end
        end
        PH_SKIP: begin
          // Bytes are dropped until the payload ends.
        end
        PH_HEADER: begin
          // The first header byte marks where the command starts.
          if (hbs == '0) begin
            start_cur  = byte_position;
            start_next = byte_position;
          end
          hw_next  = hw_ins;
          hbs_next = hbs + HDR_IDX_W'(1);
          if (hbs == HDR_LAST_IDX) begin
            ty = hw_ins[31:0];
            sz = hw_ins[63:32];
            if (sz < MIN_SIZE) begin
              emit       = 1'b1;
              st         = ST_BAD_SIZE;
              phase_next = PH_SKIP;
            end else begin
              tinv_now  = (ty == 32'd0) || (ty >= type_count);
              tinv_next = tinv_now;
              rem_next  = sz - MIN_SIZE;
              if (sz == MIN_SIZE) begin
                finish = 1'b1;
              end else if (item.is_last) begin
                emit = 1'b1;
                st   = ST_TRUNC;
              end else begin
                phase_next = PH_BODY;
              end
            end
          end else if (item.is_last) begin
            emit = 1'b1;
            st   = ST_TRUNC;
            ty   = 32'd0;
            sz   = 32'd0;
          end
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase

      // A command's last byte reports it; header next, or skip if type bad.
      if (finish) begin
        emit       = 1'b1;
        st         = tinv_now ? ST_BAD_TYPE : ST_OK;
        phase_next = tinv_now ? PH_SKIP : PH_HEADER;
        hbs_next   = '0;
        hw_next    = '0;
        tinv_next  = 1'b0;
      end

      // The final payload byte returns everything to the start of a payload.
      if (item.is_last) begin
        phase_next = PH_HEADER;
        hbs_next   = '0;
        hw_next    = '0;
        rem_next   = '0;
        start_next = '0;
        tinv_next  = 1'b0;
        pos_next   = '0;
      end else begin
        pos_next = byte_position + OFFSET_BITS'(1);
      end
    end
  end

  // Result fields; the offset is the low word of the command start.
  always_comb begin
    res.status         = st;
    res.cmd_type       = ty;
    res.command_offset = 32'(start_cur);
    res.cmd_size       = sz;
    res.payload_end    = item.is_last;
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      hbs            <= '0;
      header_word    <= '0;
      body_remaining <= '0;
      byte_position  <= '0;
      start_position <= '0;
      type_invalid   <= 1'b0;
    end else begin
      phase          <= phase_next;
      hbs            <= hbs_next;
      header_word    <= hw_next;
      body_remaining <= rem_next;
      byte_position  <= pos_next;
      start_position <= start_next;
      type_invalid   <= tinv_next;
    end
  end

  // Type count configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      type_count <= TYPE_COUNT_RESET;
    end else if (type_count_we) begin
      type_count <= type_count_wdata;
    end
  end

endmodule

FILE: src/lpcd_queue.sv
// Short result queue between the parser and the result port.
// Register array with read and write pointers; depends on lpcd_pkg.
module lpcd_queue import lpcd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  result_t wr_data,
  input  logic    rd_en,
  output result_t rd_data,
  output logic    empty,
  output logic    full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  result_t          mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign empty   = (count == '0);
  assign full    = (count == CNT_FULL);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: src/length_prefixed_command_deframer.sv
// Length-prefixed command deframer.
// Splits a byte payload into commands with an 8-byte header (type, size).
// Depends on lpcd_pkg, lpcd_parse and lpcd_queue.
//
// Usage:
//   Input channel: drive item (payload_byte, is_last) with push; a transaction
//   completes on a clock edge with push high and full low. One byte per cycle while full is low.
//   Result channel: while empty is low the oldest result is on result; it is
//   taken on an edge with pop high. Each byte yields zero or one result.
//   Configuration: type_count_we writes type_count_wdata into the type count
//   register on the same edge; write it only while the block is idle.
// Results: a taken byte's result is queued on that edge; it is on result after older ones pop.
// Throughput: one byte per cycle while full is low; the parser updates for each byte taken. The
//   two-entry result queue holds up to two results while the result side
//   stalls; full rises only when both entries hold results not yet popped.
// Reset: rst (synchronous) clears the parser to the start of a payload at
//   offset zero, empties the queue and sets the type count to 32.
// Stall: when the receiver stops popping, the queue fills, full rises and
//   input bytes are held off; nothing is lost or repeated.
module length_prefixed_command_deframer import lpcd_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  item_t       item,
  output logic        empty,
  input  logic        pop,
  output result_t     result,
  input  logic        type_count_we,
  input  logic [31:0] type_count_wdata
);

  logic    accept;
  logic    emit;
  result_t parse_res;

  assign accept = push && !full;

  // Front: byte parser and classifier.
  lpcd_parse #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parse (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .item             (item),
    .type_count_we    (type_count_we),
    .type_count_wdata (type_count_wdata),
    .emit             (emit),
    .res              (parse_res)
  );

  // Back: result queue feeding the result port.
  lpcd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (emit),
    .wr_data (parse_res),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty),
    .full    (full)
  );

  // A full queue always has a result to offer.
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("queue reports full and empty together");

  // A waiting result that is not popped stays available.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result vanished without a pop");

  // The done code is never produced.
  a_no_done: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.status != ST_DONE))
    else $error("unexpected payload done status");

  // A bad-size result carries a size below the header length.
  a_bad_size: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.status == ST_BAD_SIZE)) |-> (result.cmd_size < MIN_SIZE))
    else $error("bad size result with a legal size");

endmodule
